// ===== hdl/ngram_frequency_table_core_assert.svh =====
// assertion macros used by the ngram frequency table controller
`ifndef NGRAM_FREQUENCY_TABLE_CORE_ASSERT_SVH
`define NGRAM_FREQUENCY_TABLE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define NFT_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked on every rising clock edge outside reset
`define NFT_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define NFT_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define NFT_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== hdl/nft_pkg.sv =====
// shared types and constants of the ngram frequency table
package nft_pkg;
  localparam int unsigned Order      = 3;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = 32;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned DistW      = 11;
  localparam int unsigned FillW      = 4;
  localparam int unsigned UsedW      = AddrW + 1;
  localparam logic [63:0] HashMul    = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_CLAMP   = 2'd2;
  localparam logic [1:0] ST_FILLING = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, shift window on push
    logic hash_mul;  // first half of the hash product
    logic hash_fin;  // second half, load the probe address
    logic step;      // advance probe address
    logic alloc;     // write key into free slot
    logic update;    // write count and totals
    logic clr_start; // start clearing pass
    logic clr_step;  // clear one slot
    logic result;    // load output register
    logic [1:0] st;  // status for result
    logic zero_cnt;  // result count is zero
  } nft_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       win_full;
    logic       used;
    logic       hit;
    logic       wrapped;
    logic       delta_pos;
    logic       delta_neg;
    logic       clamp;
    logic       clr_done;
  } nft_stat_t;
endpackage

// ===== hdl/nft_ram.sv =====
// generic single port ram with registered read
module nft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write, registered read returns the contents before the write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/nft_datapath.sv =====
// datapath: window, hash, probe address, tables, totals and result register
module nft_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  nft_pkg::nft_cmd_t           ctl,
  output nft_pkg::nft_stat_t          sts,
  input  logic [1:0]                  in_cmd,
  input  logic [7:0]                  in_byte,
  input  logic [nft_pkg::KeyW-1:0]    in_key,
  input  logic [15:0]                 in_delta,
  output logic [nft_pkg::CntW-1:0]    res_count,
  output logic [nft_pkg::CntW-1:0]    res_total,
  output logic [nft_pkg::DistW-1:0]   res_distinct,
  output logic [1:0]                  res_status
);
  localparam int unsigned AW = nft_pkg::AddrW;
  localparam int unsigned WinW = 8 * nft_pkg::Order;

  logic [1:0]               cmd_r;
  logic [nft_pkg::KeyW-1:0] key_r;
  logic [15:0]              delta_r;
  logic [WinW-1:0]          win_r, win_nxt;
  logic [nft_pkg::FillW-1:0] fill_r;
  logic [31:0]              plo_r, phm_r, pmid_r;
  logic [AW-1:0]            addr_r, home_r;
  logic                     used_q;
  logic                     used_we_c;
  logic [AW-1:0]            used_addr_c;
  logic [nft_pkg::CntW-1:0] total_r;
  logic [nft_pkg::DistW-1:0] dist_r, dist_nxt;
  logic [AW:0]              clr_r;
  logic [nft_pkg::KeyW-1:0] key_q;
  logic [nft_pkg::CntW-1:0] cnt_q;
  logic [nft_pkg::CntW-1:0] old_c, new_c;
  logic [32:0]              sum_c;
  logic [15:0]              mag_c;
  logic                     clamp_c;
  logic [32:0]              tsum_c;
  logic [nft_pkg::CntW-1:0] total_nxt;
  logic [63:0]              h_c;
  logic [AW-1:0]            addr_nxt;

  // window shift and fill
  assign win_nxt = {in_byte, win_r[WinW-1:8]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (ctl.load && in_cmd == nft_pkg::CMD_PUSH) begin
      win_r <= win_nxt;
      if (fill_r < nft_pkg::FillW'(nft_pkg::Order)) fill_r <= fill_r + 1'b1;
    end else if (ctl.clr_start) begin
      win_r  <= '0;
      fill_r <= '0;
    end
  end

  // command register, a push after reset so the first clearing pass ends in idle
  always_ff @(posedge clk) begin
    if (!rst_n) cmd_r <= nft_pkg::CMD_PUSH;
    else if (ctl.load) cmd_r <= in_cmd;
  end

  // key and delta capture, a push counts its window key once
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (in_cmd == nft_pkg::CMD_PUSH) begin
        key_r   <= nft_pkg::KeyW'(win_nxt);
        delta_r <= 16'd1;
      end else begin
        key_r   <= in_key;
        delta_r <= in_delta;
      end
    end
  end

  // hash: high word of key times constant in two multiply steps
  always_ff @(posedge clk) begin
    if (ctl.hash_mul) begin
      plo_r  <= 32'((64'(key_r[31:0]) * 64'(nft_pkg::HashMul[31:0])) >> 32);
      phm_r  <= 32'(key_r[63:32] * nft_pkg::HashMul[31:0]);
      pmid_r <= 32'(key_r[31:0] * nft_pkg::HashMul[63:32]);
    end
  end
  assign h_c = {32'(plo_r + phm_r + pmid_r), 32'd0};

  // probe address
  assign addr_nxt = (addr_r == AW'(nft_pkg::TableDepth - 1)) ? '0 : addr_r + 1'b1;
  always_ff @(posedge clk) begin
    if (ctl.hash_fin) begin
      addr_r <= h_c[32 +: AW];
      home_r <= h_c[32 +: AW];
    end else if (ctl.step) begin
      addr_r <= addr_nxt;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (ctl.clr_start) clr_r <= '0;
    else if (ctl.clr_step) clr_r <= clr_r + 1'b1;
  end

  // slot occupancy ram, emptied one slot per cycle by the clearing pass
  assign used_we_c   = ctl.alloc || ctl.clr_step;
  assign used_addr_c = ctl.clr_step ? clr_r[AW-1:0] : addr_r;
  nft_ram #(.Width(1), .Depth(nft_pkg::TableDepth)) u_used_ram (
    .clk(clk), .we(used_we_c), .addr(used_addr_c), .wdata(ctl.alloc), .rdata(used_q)
  );

  nft_ram #(.Width(nft_pkg::KeyW), .Depth(nft_pkg::TableDepth)) u_key_ram (
    .clk(clk), .we(ctl.alloc), .addr(addr_r), .wdata(key_r), .rdata(key_q)
  );
  nft_ram #(.Width(nft_pkg::CntW), .Depth(nft_pkg::TableDepth)) u_cnt_ram (
    .clk(clk), .we(ctl.update), .addr(addr_r), .wdata(new_c), .rdata(cnt_q)
  );

  // count arithmetic
  assign old_c   = used_q && key_q == key_r ? cnt_q : '0;
  assign mag_c   = 16'(-delta_r);
  assign sum_c   = {1'b0, old_c} + 33'(delta_r);
  assign clamp_c = delta_r[15] && (32'(mag_c) > old_c);
  always_comb begin
    if (!delta_r[15]) new_c = sum_c[32] ? '1 : sum_c[31:0];
    else if (clamp_c) new_c = '0;
    else new_c = old_c - 32'(mag_c);
  end
  assign tsum_c = {1'b0, total_r} + {1'b0, new_c} - {1'b0, old_c};
  always_comb begin
    if (new_c >= old_c) total_nxt = tsum_c[32] ? '1 : tsum_c[31:0];
    else total_nxt = (old_c - new_c > total_r) ? '0 : tsum_c[31:0];
  end

  // distinct count moves only on changes between zero and nonzero
  always_comb begin
    dist_nxt = dist_r;
    if (old_c == '0 && new_c != '0) dist_nxt = dist_r + 1'b1;
    else if (old_c != '0 && new_c == '0) dist_nxt = dist_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      dist_r  <= '0;
    end else if (ctl.clr_start) begin
      total_r <= '0;
      dist_r  <= '0;
    end else if (ctl.update) begin
      total_r <= total_nxt;
      dist_r  <= dist_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.result) begin
      res_status <= ctl.st;
      if (ctl.zero_cnt) res_count <= '0;
      else if (ctl.update) res_count <= new_c;
      else res_count <= old_c;
      res_total    <= ctl.update ? total_nxt : (ctl.clr_start ? '0 : total_r);
      res_distinct <= ctl.update ? dist_nxt : (ctl.clr_start ? '0 : dist_r);
    end
  end

  assign sts.cmd       = cmd_r;
  assign sts.win_full  = fill_r == nft_pkg::FillW'(nft_pkg::Order);
  assign sts.used      = used_q;
  assign sts.hit       = used_q && key_q == key_r;
  assign sts.wrapped   = addr_nxt == home_r;
  assign sts.delta_pos = cmd_r == nft_pkg::CMD_PUSH || (!delta_r[15] && delta_r != '0);
  assign sts.delta_neg = cmd_r != nft_pkg::CMD_PUSH && delta_r[15];
  assign sts.clamp     = cmd_r != nft_pkg::CMD_PUSH && clamp_c;
  assign sts.clr_done  = clr_r[AW];
endmodule

// ===== hdl/nft_ctrl.sv =====
// controller state machine sequencing probe and update
`include "ngram_frequency_table_core_assert.svh"
module nft_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  nft_pkg::nft_stat_t sts,
  output nft_pkg::nft_cmd_t  ctl
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_ADDR = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] st_r, st_nxt;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    st_nxt        = st_r;
    ctl           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          ctl.load  = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        ctl.hash_mul = 1'b1;
        if (sts.cmd == nft_pkg::CMD_CLEAR) begin
          ctl.clr_start = 1'b1;
          ctl.result = 1'b1; ctl.st = nft_pkg::ST_OK; ctl.zero_cnt = 1'b1;
          state_nxt = S_CLR;
        end else if (sts.cmd == nft_pkg::CMD_PUSH && !sts.win_full) begin
          ctl.result = 1'b1; ctl.st = nft_pkg::ST_FILLING; ctl.zero_cnt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        ctl.hash_fin = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (sts.used && !sts.hit) begin
          if (sts.wrapped) begin
            if (sts.cmd == nft_pkg::CMD_QUERY) begin
              ctl.result = 1'b1; ctl.st = nft_pkg::ST_OK; ctl.zero_cnt = 1'b1;
            end else begin
              ctl.result = 1'b1; ctl.zero_cnt = 1'b1;
              ctl.st = sts.delta_pos ? nft_pkg::ST_FULL :
                       (sts.delta_neg ? nft_pkg::ST_CLAMP : nft_pkg::ST_OK);
            end
            state_nxt = S_OUT;
          end else begin
            ctl.step = 1'b1;
            state_nxt = S_RD;
          end
        end else if (sts.cmd == nft_pkg::CMD_QUERY) begin
          ctl.result = 1'b1; ctl.st = nft_pkg::ST_OK;
          state_nxt = S_OUT;
        end else if (!sts.hit && !sts.delta_pos) begin
          ctl.result = 1'b1; ctl.zero_cnt = 1'b1;
          ctl.st = sts.delta_neg ? nft_pkg::ST_CLAMP : nft_pkg::ST_OK;
          state_nxt = S_OUT;
        end else begin
          ctl.alloc = !sts.hit;
          st_nxt    = sts.clamp ? nft_pkg::ST_CLAMP : nft_pkg::ST_OK;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        ctl.update = 1'b1;
        ctl.result = 1'b1;
        ctl.st     = st_r;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      // clearing pass, answers only when a clear request started it
      S_CLR: begin
        if (sts.clr_done) begin
          state_nxt = (sts.cmd == nft_pkg::CMD_CLEAR) ? S_OUT : S_IDLE;
        end else begin
          ctl.clr_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
      st_r        <= nft_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE && !out_valid_r;
  assign out_valid = out_valid_r;

  `NFT_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `NFT_ASSERT_NXT(a_accept_hash, clk, rst_n, in_valid && in_ready, state_r == S_HASH)
  `NFT_ASSERT_NXT(a_out_follows, clk, rst_n, state_r == S_OUT, out_valid_r)
  `NFT_ASSERT_IMP(a_one_write, clk, rst_n, ctl.update, !ctl.alloc && !ctl.step)
endmodule

// ===== hdl/ngram_frequency_table_core.sv =====
// a filling push answers from the hash state through the output state, a clear after its pass
// a table command steps through hash, address, read and evaluate, then update if the count is
// written; read and evaluate repeat for each extra slot probed; one request at a time
// a request is taken only once the previous result has left the output register
// reset (synchronous, rst_n low) zeroes window, total and distinct count, then a
// clearing pass frees every slot before in_tready rises
module ngram_frequency_table_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,  // cmd[1:0], text_byte[9:2], ngram_key[73:10], delta[89:74]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata  // key_count, total_ngrams, distinct_ngrams, status
);
  nft_pkg::nft_cmd_t  ctl;
  nft_pkg::nft_stat_t sts;
  logic [31:0] res_count, res_total;
  logic [10:0] res_distinct;
  logic [1:0]  res_status;

  nft_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .sts(sts), .ctl(ctl)
  );

  nft_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_tdata[1:0]), .in_byte(in_tdata[9:2]), .in_key(in_tdata[73:10]),
    .in_delta(in_tdata[89:74]), .res_count(res_count), .res_total(res_total),
    .res_distinct(res_distinct), .res_status(res_status)
  );

  assign out_tdata = {3'd0, res_status, res_distinct, res_total, res_count};
endmodule

// ===== tb/sv/tb_ngram_frequency_table_core.sv =====
// self-checking testbench for the ngram frequency table core
module tb_ngram_frequency_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        drain;   // hold the request until all results are back
    logic [1:0]  cmd;
    logic [7:0]  text_byte;
    logic [63:0] ngram_key;
    logic [15:0] delta;
  } freq_req_t;

  // highest field first, so key_count lands in the low bits
  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] distinct_ngrams;
    logic [31:0] total_ngrams;
    logic [31:0] key_count;
  } freq_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  freq_req_t  pending_reqs[$];
  freq_resp_t due_results[$];
  freq_req_t  cur_req;
  bit         failed = 1'b0;

  // predicted table contents
  bit [63:0] key_tbl[nft_pkg::TableDepth];
  bit        used_tbl[nft_pkg::TableDepth];
  bit [31:0] cnt_tbl[nft_pkg::TableDepth];
  bit [63:0] win_bytes = '0;
  int        win_fill = 0;
  bit [31:0] total_cnt = '0;
  bit [10:0] nonzero_cnt = '0;

  ngram_frequency_table_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  // linear probe from the hashed home slot
  function automatic void find_slot(input bit [63:0] key, output int slot, output bit hit);
    bit [63:0] h;
    int s;
    h = key * nft_pkg::HashMul;
    s = int'(h[63:32] % nft_pkg::TableDepth);
    hit = 1'b0;
    slot = -1;
    for (int i = 0; i < nft_pkg::TableDepth; i++) begin
      if (!used_tbl[s]) begin
        slot = s;
        return;
      end
      if (key_tbl[s] == key) begin
        slot = s;
        hit = 1'b1;
        return;
      end
      s = (s + 1 == nft_pkg::TableDepth) ? 0 : s + 1;
    end
  endfunction

  // signed count change with clamping and saturation
  function automatic logic [1:0] change_count(input bit [63:0] key, input int d,
                                              output bit [31:0] cnt);
    int s;
    bit hit;
    longint unsigned old_c, new_c, t;
    logic [1:0] st;
    st = nft_pkg::ST_OK;
    cnt = '0;
    find_slot(key, s, hit);
    if (!hit) begin
      if (d <= 0) return (d < 0) ? nft_pkg::ST_CLAMP : nft_pkg::ST_OK;
      if (s < 0) return nft_pkg::ST_FULL;
      used_tbl[s] = 1'b1;
      key_tbl[s] = key;
      cnt_tbl[s] = '0;
    end
    old_c = cnt_tbl[s];
    if (d >= 0) begin
      new_c = old_c + longint'(d);
      if (new_c > 64'hFFFF_FFFF) new_c = 64'hFFFF_FFFF;
    end else if (longint'(-d) > old_c) begin
      new_c = 0;
      st = nft_pkg::ST_CLAMP;
    end else begin
      new_c = old_c - longint'(-d);
    end
    cnt_tbl[s] = new_c[31:0];
    if (new_c > old_c) begin
      t = total_cnt + (new_c - old_c);
      total_cnt = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    end else begin
      t = old_c - new_c;
      total_cnt = (t > total_cnt) ? 32'd0 : total_cnt - t[31:0];
    end
    if (old_c == 0 && new_c != 0) nonzero_cnt++;
    else if (old_c != 0 && new_c == 0) nonzero_cnt--;
    cnt = new_c[31:0];
    return st;
  endfunction

  function automatic freq_resp_t predict_counts(input freq_req_t r);
    freq_resp_t res;
    bit [31:0] cnt;
    int s;
    bit hit;
    cnt = '0;
    res.status = nft_pkg::ST_OK;
    case (r.cmd)
      nft_pkg::CMD_PUSH: begin
        win_bytes = ((win_bytes >> 8) |
                     (64'(r.text_byte) << (8 * (nft_pkg::Order - 1))))
                    & ((nft_pkg::Order >= 8) ? ~64'd0 :
                       ((64'd1 << (8 * nft_pkg::Order)) - 1));
        if (win_fill < nft_pkg::Order) win_fill++;
        if (win_fill < nft_pkg::Order) res.status = nft_pkg::ST_FILLING;
        else res.status = change_count(win_bytes, 1, cnt);
      end
      nft_pkg::CMD_ADD: res.status = change_count(r.ngram_key, int'($signed(r.delta)), cnt);
      nft_pkg::CMD_QUERY: begin
        find_slot(r.ngram_key, s, hit);
        if (hit) cnt = cnt_tbl[s];
      end
      default: begin
        for (int i = 0; i < nft_pkg::TableDepth; i++) used_tbl[i] = 1'b0;
        total_cnt = '0;
        nonzero_cnt = '0;
        win_bytes = '0;
        win_fill = 0;
      end
    endcase
    res.key_count = cnt;
    res.total_ngrams = total_cnt;
    res.distinct_ngrams = nonzero_cnt;
    return res;
  endfunction

  // request sender: random gaps with back-to-back stretches
  int  send_gap = 0;
  bit  send_burst = 1'b0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        due_results = {due_results, predict_counts(cur_req)};
        if ($urandom_range(0, 59) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 18);
      end
      if ((in_tvalid && in_tready) || !in_tvalid) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && due_results.size() > 0)) begin
          cur_req = pending_reqs.pop_front();
          in_tdata <= {6'b0, cur_req.delta, cur_req.ngram_key, cur_req.text_byte, cur_req.cmd};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker, one long hold-off early in the run
  int  recv_hold = 0;
  int  resp_seen = 0;
  bit  recv_burst = 1'b0;
  freq_resp_t got, want;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[76:0];
        resp_seen++;
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, got);
          failed = 1'b1;
        end else begin
          want = due_results.pop_front();
          if (got.key_count !== want.key_count) begin
            $display("%0t: key_count exp %0d got %0d", $realtime, want.key_count, got.key_count);
            failed = 1'b1;
          end
          if (got.total_ngrams !== want.total_ngrams) begin
            $display("%0t: total_ngrams exp %0d got %0d", $realtime,
                     want.total_ngrams, got.total_ngrams);
            failed = 1'b1;
          end
          if (got.distinct_ngrams !== want.distinct_ngrams) begin
            $display("%0t: distinct_ngrams exp %0d got %0d", $realtime,
                     want.distinct_ngrams, got.distinct_ngrams);
            failed = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
            failed = 1'b1;
          end
        end
        if ($urandom_range(0, 49) == 0) recv_burst = ~recv_burst;
        if (resp_seen == 120) recv_hold = 400;
        else recv_hold = recv_burst ? 0 : $urandom_range(0, 18);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic queue_req(input logic [1:0] cmd, input logic [7:0] b,
                           input logic [63:0] key, input logic [15:0] d,
                           input logic drain = 1'b0);
    freq_req_t r;
    r.drain = drain;
    r.cmd = cmd;
    r.text_byte = b;
    r.ngram_key = key;
    r.delta = d;
    pending_reqs = {pending_reqs, r};
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(0, 3))
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // request mix: half text pushes, the rest adds and queries on known keys, new keys and rare clears
  task automatic queue_random(input int n, inout logic [63:0] known[$]);
    logic [63:0] k;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      k = (known.size() > 0) ? known[$urandom_range(0, known.size() - 1)] : rand_key();
      if (pick < 50)
        queue_req(nft_pkg::CMD_PUSH, ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                  8'($urandom_range(8'h61, 8'h64)), rand_key(), 16'($urandom()));
      else if (pick < 70)
        queue_req(nft_pkg::CMD_ADD, 8'($urandom()), k, rand_delta());
      else if (pick < 88)
        queue_req(nft_pkg::CMD_QUERY, 8'($urandom()), k, 16'($urandom()));
      else if (pick < 90)
        queue_req(nft_pkg::CMD_CLEAR, 8'($urandom()), rand_key(), 16'($urandom()));
      else begin
        k = rand_key();
        known = {known, k};
        queue_req(nft_pkg::CMD_ADD, 8'($urandom()), k, rand_delta());
      end
    end
  endtask

  initial begin
    logic [63:0] known[$];
    logic [63:0] kfull;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: window filling, extremes, clamps, absent keys, clear
    queue_req(nft_pkg::CMD_PUSH, 8'h00, '0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'hFF, '0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h80, '0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h00, '0, '0);
    queue_req(nft_pkg::CMD_QUERY, '0, 64'h0000_0000_0080_FF00, '0);
    queue_req(nft_pkg::CMD_QUERY, '0, 64'h0000_0000_0000_80FF, '0);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'h7FFF);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'h7FFF);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'h8000);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'h8000);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'h0005);
    queue_req(nft_pkg::CMD_ADD, '0, ~64'd0, 16'hFFFB);
    queue_req(nft_pkg::CMD_ADD, '0, 64'h0, 16'h0000);
    queue_req(nft_pkg::CMD_ADD, '0, 64'h0, 16'hFFFF);
    queue_req(nft_pkg::CMD_QUERY, '0, 64'h0, '0);
    queue_req(nft_pkg::CMD_QUERY, '0, ~64'd0, '0);
    queue_req(nft_pkg::CMD_ADD, '0, 64'h0, 16'h0001);
    queue_req(nft_pkg::CMD_CLEAR, 8'hFF, ~64'd0, 16'hFFFF);
    queue_req(nft_pkg::CMD_QUERY, '0, 64'h0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h55, '0, '0);
    known = {known, ~64'd0};
    known = {known, 64'h0};

    // random text and key traffic, one pause until all results are back
    queue_random(150, known);
    queue_req(nft_pkg::CMD_QUERY, '0, ~64'd0, '0, 1'b1);
    queue_random(150, known);

    // fill every slot, then hit the full table
    queue_req(nft_pkg::CMD_CLEAR, '0, '0, '0, 1'b1);
    for (int i = 0; i < nft_pkg::TableDepth; i++)
      queue_req(nft_pkg::CMD_ADD, '0, {$urandom(), 22'($urandom()), 10'(i)},
                16'($urandom_range(1, 32767)));
    kfull = {$urandom(), 22'($urandom()), 10'd0} ^ 64'h3;
    queue_req(nft_pkg::CMD_ADD, '0, kfull, 16'h0010);
    queue_req(nft_pkg::CMD_ADD, '0, kfull, 16'hFFF0);
    queue_req(nft_pkg::CMD_ADD, '0, kfull, 16'h0000);
    queue_req(nft_pkg::CMD_QUERY, '0, kfull, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h31, '0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h32, '0, '0);
    queue_req(nft_pkg::CMD_PUSH, 8'h33, '0, '0);
    queue_req(nft_pkg::CMD_CLEAR, '0, '0, '0);

    known.delete();
    queue_random(100, known);

    while (pending_reqs.size() > 0 || in_tvalid || due_results.size() > 0)
      @(posedge clk);
    repeat (3000) @(posedge clk);
    if (!failed && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #100ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
